// ----- rtl/core/sachm_pkg.sv -----
// Shared constants and types for the set-associative cache hit/miss unit.
`timescale 1ns / 1ps
`default_nettype none

package sachm_pkg;

    localparam int MAX_SETS        = 64;
    localparam int MAX_WAYS        = 8;
    localparam int ADDR_W          = 16;
    localparam int MAX_BLOCK_WORDS = 256;

    localparam int SET_W   = $clog2(MAX_SETS);
    localparam int WAY_W   = $clog2(MAX_WAYS);
    localparam int SLOT_W  = SET_W + WAY_W;
    localparam int SLOTS   = MAX_SETS * MAX_WAYS;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;

    // configuration field widths
    localparam int POL_W  = 2;
    localparam int WPB_W  = 9;
    localparam int SETC_W = 7;
    localparam int WAYC_W = 4;
    localparam int CFG_W  = 9;
    localparam int CFGI_W = 2;

    // divider divisor width covers both the block size and the set count
    localparam int DVS_W = WPB_W;

    localparam logic [CFGI_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_WPB    = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_SETS   = 2'd2;
    localparam logic [CFGI_W-1:0] CFG_WAYS   = 2'd3;

    localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
    localparam logic [POL_W-1:0] POL_LRU  = 2'd1;
    localparam logic [POL_W-1:0] POL_MRU  = 2'd2;

    typedef struct packed {
        logic                en;
        logic                fill;   // 1: tag, fill and use stamp; 0: use stamp only
        logic [SLOT_W-1:0]   slot;
        logic [ADDR_W-1:0]   tag;
        logic [STAMP_W-1:0]  stamp;
    } slot_wr_t;

    typedef struct packed {
        logic                en;
        logic [SET_W-1:0]    row;
        logic [MAX_WAYS-1:0] bits;
    } row_wr_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  tag;
        logic [STAMP_W-1:0] fill_stamp;
        logic [STAMP_W-1:0] use_stamp;
    } slot_rd_t;

endpackage

`default_nettype wire

// ----- rtl/core/set_assoc_cache_hit_miss_model_unit.sv -----
// Top level: set-associative cache hit/miss model with FIFO, LRU or MRU replacement.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | s_word_address
//  m_      | out       | m_valid / m_ready    | m_hit, m_set_index, m_way_index,
//          |           |                      | m_block_base, m_hit_total, m_miss_total
//  cfg_    | in        | cfg_we               | cfg_index, cfg_data
//
// Each item passes in turn through two runs of the shared divider (block number, then
// set), each shifting out all 16 quotient bits before done; a read of the slot
// memories for each way searched (ST_LOOK, then ST_CHECK); the write-back and result
// load in ST_FINISH; and ST_IDLE, where s_ready is high.
// After reset a pass clears all 64 valid rows; s_ready stays low meanwhile.
// A held result stalls only the write-back; the next item is taken once it is loaded.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_hit_miss_model_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [sachm_pkg::ADDR_W-1:0]  s_word_address,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_hit,
    output logic [sachm_pkg::SET_W-1:0]        m_set_index,
    output logic [sachm_pkg::WAY_W-1:0]        m_way_index,
    output logic [sachm_pkg::ADDR_W-1:0]       m_block_base,
    output logic [sachm_pkg::CNT_W-1:0]        m_hit_total,
    output logic [sachm_pkg::CNT_W-1:0]        m_miss_total,
    input  wire logic                          cfg_we,
    input  wire logic [sachm_pkg::CFGI_W-1:0]  cfg_index,
    input  wire logic [sachm_pkg::CFG_W-1:0]   cfg_data
);

    typedef enum logic [6:0] {
        ST_CLEAR   = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_DIV_BLK = 7'b0000100,
        ST_DIV_SET = 7'b0001000,
        ST_LOOK    = 7'b0010000,
        ST_CHECK   = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } state_t;

    localparam int SET_W   = sachm_pkg::SET_W;
    localparam int WAY_W   = sachm_pkg::WAY_W;
    localparam int ADDR_W  = sachm_pkg::ADDR_W;
    localparam int STAMP_W = sachm_pkg::STAMP_W;
    localparam int CNT_W   = sachm_pkg::CNT_W;
    localparam int WPB_W   = sachm_pkg::WPB_W;
    localparam int SETC_W  = sachm_pkg::SETC_W;
    localparam int WAYC_W  = sachm_pkg::WAYC_W;
    localparam int DVS_W   = sachm_pkg::DVS_W;
    localparam int MAX_WAYS = sachm_pkg::MAX_WAYS;

    state_t state_reg, state_next;

    // configuration
    logic [sachm_pkg::POL_W-1:0] policy_reg;
    logic [WPB_W-1:0]            wpb_reg;
    logic [SETC_W-1:0]           setc_reg;
    logic [WAYC_W-1:0]           wayc_reg;

    logic [WPB_W-1:0]  wpb_eff;
    logic [SETC_W-1:0] sets_eff;
    logic [WAYC_W-1:0] ways_eff;

    always_comb begin
        if (wpb_reg == '0) begin
            wpb_eff = WPB_W'(1);
        end else if (wpb_reg > WPB_W'(sachm_pkg::MAX_BLOCK_WORDS)) begin
            wpb_eff = WPB_W'(sachm_pkg::MAX_BLOCK_WORDS);
        end else begin
            wpb_eff = wpb_reg;
        end
        if (setc_reg == '0) begin
            sets_eff = SETC_W'(1);
        end else if (setc_reg > SETC_W'(sachm_pkg::MAX_SETS)) begin
            sets_eff = SETC_W'(sachm_pkg::MAX_SETS);
        end else begin
            sets_eff = setc_reg;
        end
        if (wayc_reg == '0) begin
            ways_eff = WAYC_W'(1);
        end else if (wayc_reg > WAYC_W'(MAX_WAYS)) begin
            ways_eff = WAYC_W'(MAX_WAYS);
        end else begin
            ways_eff = wayc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= sachm_pkg::POL_FIFO;
            wpb_reg    <= WPB_W'(1);
            setc_reg   <= SETC_W'(1);
            wayc_reg   <= WAYC_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                sachm_pkg::CFG_POLICY: policy_reg <= cfg_data[sachm_pkg::POL_W-1:0];
                sachm_pkg::CFG_WPB:    wpb_reg    <= cfg_data[WPB_W-1:0];
                sachm_pkg::CFG_SETS:   setc_reg   <= cfg_data[SETC_W-1:0];
                sachm_pkg::CFG_WAYS:   wayc_reg   <= cfg_data[WAYC_W-1:0];
                default: ;
            endcase
        end
    end

    // shared divider
    logic                 div_start;
    logic [ADDR_W-1:0]    div_dividend;
    logic [DVS_W-1:0]     div_divisor;
    logic                 div_done;
    logic [ADDR_W-1:0]    div_quot;
    logic [DVS_W-1:0]     div_rem;

    sachm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // storage
    sachm_pkg::slot_wr_t         slot_wr;
    sachm_pkg::row_wr_t          row_wr;
    sachm_pkg::slot_rd_t         slot_rd;
    logic [MAX_WAYS-1:0]         row_rd;

    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  base_reg;
    logic [SET_W-1:0]   set_reg;
    logic [WAY_W-1:0]   way_reg;
    logic [WAY_W-1:0]   best_reg;
    logic [STAMP_W-1:0] key_reg;
    logic [WAY_W-1:0]   fin_way_reg;
    logic               fin_hit_reg;
    logic [SET_W-1:0]   clr_cnt_reg;
    logic [STAMP_W-1:0] access_reg;
    logic [CNT_W-1:0]   hit_cnt_reg;
    logic [CNT_W-1:0]   miss_cnt_reg;

    sachm_store u_store (
        .aclk      (aclk),
        .slot_wr   (slot_wr),
        .row_wr    (row_wr),
        .slot_addr ({set_reg, way_reg}),
        .row_addr  (set_reg),
        .slot_rd   (slot_rd),
        .row_rd    (row_rd)
    );

    // output register
    logic              m_valid_reg;
    logic              m_hit_reg;
    logic [SET_W-1:0]  m_set_reg;
    logic [WAY_W-1:0]  m_way_reg;
    logic [ADDR_W-1:0] m_base_reg;
    logic [CNT_W-1:0]  m_hits_reg;
    logic [CNT_W-1:0]  m_misses_reg;

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    logic s_fire;
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // way scan
    logic               way_valid;
    logic               tag_match;
    logic [STAMP_W-1:0] key_val;
    logic               better;
    logic               last_way;
    logic [WAY_W-1:0]   best_cand;
    logic [STAMP_W-1:0] key_cand;

    assign way_valid = row_rd[way_reg];
    assign tag_match = (slot_rd.tag == base_reg);
    assign key_val   = (policy_reg == sachm_pkg::POL_LRU || policy_reg == sachm_pkg::POL_MRU)
                       ? slot_rd.use_stamp : slot_rd.fill_stamp;
    assign better    = (policy_reg == sachm_pkg::POL_MRU) ? (key_val > key_reg)
                                                         : (key_val < key_reg);
    assign last_way  = ({1'b0, way_reg} == (ways_eff - WAYC_W'(1)));
    // first way seeds the key; ties keep the lower way
    assign best_cand = (way_reg == '0 || better) ? way_reg : best_reg;
    assign key_cand  = (way_reg == '0 || better) ? key_val : key_reg;

    logic finish_go;
    assign finish_go = (state_reg == ST_FINISH) && out_free;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = s_word_address;
        div_divisor  = wpb_eff;
        if (state_reg == ST_IDLE && s_fire) begin
            div_start = 1'b1;
        end else if (state_reg == ST_DIV_BLK && div_done) begin
            div_start    = 1'b1;
            div_dividend = div_quot;
            div_divisor  = DVS_W'(sets_eff);
        end
    end

    always_comb begin
        slot_wr.en    = finish_go;
        slot_wr.fill  = !fin_hit_reg;
        slot_wr.slot  = {set_reg, fin_way_reg};
        slot_wr.tag   = base_reg;
        slot_wr.stamp = access_reg;
        if (state_reg == ST_CLEAR) begin
            row_wr.en   = 1'b1;
            row_wr.row  = clr_cnt_reg;
            row_wr.bits = '0;
        end else begin
            row_wr.en   = finish_go && !fin_hit_reg;
            row_wr.row  = set_reg;
            row_wr.bits = row_rd | (MAX_WAYS'(1) << fin_way_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == SET_W'(sachm_pkg::MAX_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_DIV_BLK;
                end
            end
            ST_DIV_BLK: begin
                if (div_done) begin
                    state_next = ST_DIV_SET;
                end
            end
            ST_DIV_SET: begin
                if (div_done) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: state_next = ST_CHECK;
            ST_CHECK: begin
                if (!way_valid || tag_match || last_way) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_LOOK;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            access_reg   <= STAMP_W'(1);
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
            end
            if (finish_go) begin
                access_reg <= access_reg + STAMP_W'(1);
                if (fin_hit_reg && hit_cnt_reg != '1) begin
                    hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
                end
                if (!fin_hit_reg && miss_cnt_reg != '1) begin
                    miss_cnt_reg <= miss_cnt_reg + CNT_W'(1);
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            addr_reg <= s_word_address;
        end
        if (state_reg == ST_DIV_BLK && div_done) begin
            // block base is the address less its offset inside the block
            base_reg <= addr_reg - ADDR_W'(div_rem);
        end
        if (state_reg == ST_DIV_SET && div_done) begin
            set_reg <= div_rem[SET_W-1:0];
            way_reg <= '0;
        end
        if (state_reg == ST_CHECK) begin
            best_reg <= best_cand;
            key_reg  <= key_cand;
            if (!way_valid) begin
                fin_hit_reg <= 1'b0;
                fin_way_reg <= way_reg;
            end else if (tag_match) begin
                fin_hit_reg <= 1'b1;
                fin_way_reg <= way_reg;
            end else if (last_way) begin
                fin_hit_reg <= 1'b0;
                fin_way_reg <= best_cand;
            end else begin
                way_reg <= way_reg + WAY_W'(1);
            end
        end
        if (finish_go) begin
            m_hit_reg  <= fin_hit_reg;
            m_set_reg  <= set_reg;
            m_way_reg  <= fin_way_reg;
            m_base_reg <= base_reg;
            if (fin_hit_reg) begin
                m_hits_reg   <= (hit_cnt_reg != '1) ? hit_cnt_reg + CNT_W'(1) : hit_cnt_reg;
                m_misses_reg <= miss_cnt_reg;
            end else begin
                m_hits_reg   <= hit_cnt_reg;
                m_misses_reg <= (miss_cnt_reg != '1) ? miss_cnt_reg + CNT_W'(1)
                                                     : miss_cnt_reg;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_set_index  = m_set_reg;
    assign m_way_index  = m_way_reg;
    assign m_block_base = m_base_reg;
    assign m_hit_total  = m_hits_reg;
    assign m_miss_total = m_misses_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sachm_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sachm_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [sachm_pkg::ADDR_W-1:0]  dividend,
    input  wire logic [sachm_pkg::DVS_W-1:0]   divisor,
    output logic                               done,
    output logic [sachm_pkg::ADDR_W-1:0]       quotient,
    output logic [sachm_pkg::DVS_W-1:0]        remainder
);

    localparam int STEP_W = $clog2(sachm_pkg::ADDR_W + 1);

    logic [sachm_pkg::ADDR_W-1:0] quo_reg, quo_next;
    logic [sachm_pkg::DVS_W-1:0]  rem_reg, rem_next;
    logic [sachm_pkg::DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0]            cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;

    logic [sachm_pkg::DVS_W:0] shifted;
    logic [sachm_pkg::DVS_W:0] dvs_ext;
    logic [sachm_pkg::DVS_W:0] diff;
    logic                      ge;

    // remainder stays below the divisor, so the shifted value fits one extra bit
    assign shifted = {rem_reg, quo_reg[sachm_pkg::ADDR_W-1]};
    assign dvs_ext = {1'b0, dvs_reg};
    assign ge      = (shifted >= dvs_ext);
    assign diff    = shifted - dvs_ext;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = STEP_W'(sachm_pkg::ADDR_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[sachm_pkg::ADDR_W-2:0], ge};
            rem_next = ge ? diff[sachm_pkg::DVS_W-1:0] : shifted[sachm_pkg::DVS_W-1:0];
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sachm_store.sv -----
// Way storage: tag and stamp memories per slot, valid bits per set row.
`timescale 1ns / 1ps
`default_nettype none

module sachm_store (
    input  wire logic                          aclk,
    input  wire sachm_pkg::slot_wr_t           slot_wr,
    input  wire sachm_pkg::row_wr_t            row_wr,
    input  wire logic [sachm_pkg::SLOT_W-1:0]  slot_addr,
    input  wire logic [sachm_pkg::SET_W-1:0]   row_addr,
    output sachm_pkg::slot_rd_t                slot_rd,
    output logic [sachm_pkg::MAX_WAYS-1:0]     row_rd
);

    logic [sachm_pkg::ADDR_W-1:0]   tag_mem   [sachm_pkg::SLOTS];
    logic [sachm_pkg::STAMP_W-1:0]  fill_mem  [sachm_pkg::SLOTS];
    logic [sachm_pkg::STAMP_W-1:0]  use_mem   [sachm_pkg::SLOTS];
    logic [sachm_pkg::MAX_WAYS-1:0] valid_mem [sachm_pkg::MAX_SETS];

    always_ff @(posedge aclk) begin
        if (slot_wr.en) begin
            use_mem[slot_wr.slot] <= slot_wr.stamp;
            if (slot_wr.fill) begin
                tag_mem[slot_wr.slot]  <= slot_wr.tag;
                fill_mem[slot_wr.slot] <= slot_wr.stamp;
            end
        end
        slot_rd.tag        <= tag_mem[slot_addr];
        slot_rd.fill_stamp <= fill_mem[slot_addr];
        slot_rd.use_stamp  <= use_mem[slot_addr];
    end

    always_ff @(posedge aclk) begin
        if (row_wr.en) begin
            valid_mem[row_wr.row] <= row_wr.bits;
        end
        row_rd <= valid_mem[row_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/sachm_checker.sv -----
// Port-level checks for the cache hit/miss unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sachm_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic                          m_hit,
    input wire logic [sachm_pkg::SET_W-1:0]   m_set_index,
    input wire logic [sachm_pkg::WAY_W-1:0]   m_way_index,
    input wire logic [sachm_pkg::ADDR_W-1:0]  m_block_base,
    input wire logic [sachm_pkg::CNT_W-1:0]   m_hit_total,
    input wire logic [sachm_pkg::CNT_W-1:0]   m_miss_total
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_set_index)
            && $stable(m_way_index) && $stable(m_block_base)
            && $stable(m_hit_total) && $stable(m_miss_total))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after an accepted item");

    // a hit result has counted at least one hit, a miss at least one miss
    a_totals: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_hit || m_hit_total != '0) && (m_hit || m_miss_total != '0))
        else $error("totals do not cover the reported result");

    // a new result only appears out of a busy period
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while idle");

endmodule

bind set_assoc_cache_hit_miss_model_unit sachm_checker u_sachm_checker (.*);

`default_nettype wire
